// ===== src/dual_fletcher_checksum_unit_defines.svh =====
// Assertion macros used by the checker file of the checksum unit.
`ifndef DUAL_FLETCHER_CHECKSUM_UNIT_DEFINES_SVH
`define DUAL_FLETCHER_CHECKSUM_UNIT_DEFINES_SVH

// Clocked assertion with an explicit disable condition.
`define DFC_ASSERT_DIS(label, dis, prop) \
  label: assert property (@(posedge clk_i) disable iff (dis) prop) \
    else $error("dual_fletcher_checksum_unit: assertion failed");

// Clocked assertion that is off while reset is applied.
`define DFC_ASSERT(label, prop) \
  `DFC_ASSERT_DIS(label, !rst_ni, prop)

`endif

// ===== src/dfc_pkg.sv =====
// Package with the types, constants and fold functions of the checksum unit.
`default_nettype none

package dfc_pkg;

  // Default fold intervals of the two accumulator pairs.
  localparam int unsigned BYTE_BLOCK_DEF = 21;
  localparam int unsigned HALF_BLOCK_DEF = 360;

  // Start values of the sums.
  localparam logic [31:0] BYTE_SUM_INIT = 32'h0000_00FF;
  localparam logic [31:0] HALF_SUM_INIT = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_HALF = 2'd2,
    CMD_WORD = 2'd3
  } dfc_cmd_e;

  // The four running sums, as seen by the result logic.
  typedef struct packed {
    logic [31:0] byte_a;
    logic [31:0] byte_b;
    logic [31:0] half_a;
    logic [31:0] half_b;
  } dfc_sums_t;

  localparam dfc_sums_t RESET_SUMS = '{
    byte_a: BYTE_SUM_INIT,
    byte_b: BYTE_SUM_INIT,
    half_a: HALF_SUM_INIT,
    half_b: HALF_SUM_INIT
  };

  // Fold a sum once at bit 8: low byte plus everything above it.
  function automatic logic [31:0] fold8(input logic [31:0] x);
    return {24'd0, x[7:0]} + {8'd0, x[31:8]};
  endfunction

  // Fold a sum once at bit 16: low half plus upper half.
  function automatic logic [31:0] fold16(input logic [31:0] x);
    return {16'd0, x[15:0]} + {16'd0, x[31:16]};
  endfunction

  // Combined checksum: packed 16-bit pair plus packed 8-bit pair, mod 2^32.
  function automatic logic [31:0] combine(input dfc_sums_t s);
    logic [31:0] fa8;
    logic [31:0] fb8;
    logic [31:0] fa16;
    logic [31:0] fb16;
    logic [31:0] big;
    logic [31:0] little;
    fa8    = fold8(s.byte_a);
    fb8    = fold8(s.byte_b);
    fa16   = fold16(s.half_a);
    fb16   = fold16(s.half_b);
    big    = {fb16[15:0], 16'd0} | fa16;
    little = {fb8[23:0], 8'd0} | fa8;
    return big + little;
  endfunction

endpackage

`default_nettype wire

// ===== src/dfc_accum.sv =====
// Accumulator state of the checksum unit: both Fletcher pairs and their fold counters.
`default_nettype none

module dfc_accum
  import dfc_pkg::*;
#(
  parameter int unsigned BYTE_BLOCK = BYTE_BLOCK_DEF,
  parameter int unsigned HALF_BLOCK = HALF_BLOCK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        upd_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] value_i,
  output dfc_sums_t        sums_o
);

  localparam int unsigned ByteCntW = $clog2(BYTE_BLOCK + 1);
  localparam int unsigned HalfCntW = $clog2(HALF_BLOCK + 1);

  typedef struct packed {
    logic [31:0]         a;
    logic [31:0]         b;
    logic [ByteCntW-1:0] cnt;
  } byte_st_t;

  typedef struct packed {
    logic [31:0]         a;
    logic [31:0]         b;
    logic [HalfCntW-1:0] cnt;
  } half_st_t;

  // One byte update, folding both sums when the countdown runs out.
  function automatic byte_st_t byte_step(input byte_st_t s, input logic [7:0] d);
    byte_st_t r;
    r.a = s.a + {24'd0, d};
    r.b = s.b + r.a;
    if (s.cnt <= ByteCntW'(1)) begin
      r.a   = fold8(r.a);
      r.b   = fold8(r.b);
      r.cnt = ByteCntW'(BYTE_BLOCK);
    end else begin
      r.cnt = s.cnt - ByteCntW'(1);
    end
    return r;
  endfunction

  // One halfword update, folding both sums when the countdown runs out.
  function automatic half_st_t half_step(input half_st_t s, input logic [15:0] d);
    half_st_t r;
    r.a = s.a + {16'd0, d};
    r.b = s.b + r.a;
    if (s.cnt <= HalfCntW'(1)) begin
      r.a   = fold16(r.a);
      r.b   = fold16(r.b);
      r.cnt = HalfCntW'(HALF_BLOCK);
    end else begin
      r.cnt = s.cnt - HalfCntW'(1);
    end
    return r;
  endfunction

  byte_st_t byte_q, byte_d;
  half_st_t half_q, half_d;
  half_st_t half_lo;
  dfc_cmd_e cmd;

  assign cmd = dfc_cmd_e'(command_i);

  // Next state; a word runs the low half first and the high half on its result.
  always_comb begin
    byte_d  = byte_q;
    half_d  = half_q;
    half_lo = half_step(half_q, value_i[15:0]);
    case (cmd)
      CMD_INIT: begin
        byte_d = '{a: BYTE_SUM_INIT, b: BYTE_SUM_INIT, cnt: ByteCntW'(BYTE_BLOCK)};
        half_d = '{a: HALF_SUM_INIT, b: HALF_SUM_INIT, cnt: HalfCntW'(HALF_BLOCK)};
      end
      CMD_BYTE: byte_d = byte_step(byte_q, value_i[7:0]);
      CMD_HALF: half_d = half_lo;
      CMD_WORD: half_d = half_step(half_lo, value_i[31:16]);
      default:  half_d = half_q;
    endcase
  end

  // State registers, loaded on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '{a: BYTE_SUM_INIT, b: BYTE_SUM_INIT, cnt: ByteCntW'(BYTE_BLOCK)};
      half_q <= '{a: HALF_SUM_INIT, b: HALF_SUM_INIT, cnt: HalfCntW'(HALF_BLOCK)};
    end else if (upd_i) begin
      byte_q <= byte_d;
      half_q <= half_d;
    end
  end

  assign sums_o = '{byte_a: byte_q.a, byte_b: byte_q.b, half_a: half_q.a, half_b: half_q.b};

endmodule

`default_nettype wire

// ===== src/dual_fletcher_checksum_unit.sv =====
// Top level of the dual Fletcher checksum unit: handshakes, state and result register.
`default_nettype none

// The unit accepts one command per clock cycle while the input is not stalled
// and returns one checksum for each, offered once the result register is free.
// At the transfer edge the accumulator registers take the updated sums (a word
// command runs two halfword updates chained in series); once the pending flag
// is set and the result register is free, the folded and combined checksum of
// that state goes to the result register. A finished result may wait in it
// while the next command is taken into the accumulators, so the input stalls
// only when a command is pending and the result register is full and unread.

module dual_fletcher_checksum_unit
  import dfc_pkg::*;
#(
  parameter int unsigned BYTE_BLOCK = BYTE_BLOCK_DEF,
  parameter int unsigned HALF_BLOCK = HALF_BLOCK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      checksum_o
);

  dfc_sums_t   sums;
  logic        in_xfer;
  logic        load_out;
  logic        pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] checksum_q;

  // A new transfer is taken unless a result is pending and the output is stalled.
  assign in_ready_o = !pend_q || !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_out   = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    pend_d      = in_xfer || (pend_q && !load_out);
    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  dfc_accum #(
    .BYTE_BLOCK(BYTE_BLOCK),
    .HALF_BLOCK(HALF_BLOCK)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (in_xfer),
    .command_i(command_i),
    .value_i  (value_i),
    .sums_o   (sums)
  );

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, written from the state left by the pending command.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      checksum_q <= combine(sums);
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

`default_nettype wire

// ===== src/dfc_checker.sv =====
// Port-level checker of the checksum unit and the bind that attaches it.
`default_nettype none

`include "dual_fletcher_checksum_unit_defines.svh"

module dfc_checker
  import dfc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  command_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] checksum_o
);

  logic init_xfer;

  assign init_xfer = in_valid_i && in_ready_o && (command_i == CMD_INIT);

  // A result that is not taken stays offered.
  `DFC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // A stalled result keeps its value.
  `DFC_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(checksum_o))

  // Checks that every accepted transfer is followed by an offered result.
  `DFC_ASSERT(a_latency, in_valid_i && in_ready_o |-> ##2 out_valid_o)

  // The input stalls only behind a full, stalled result register.
  `DFC_ASSERT(a_ready, !in_ready_o |-> out_valid_o && !out_ready_i)

  // An init with nothing ahead of it returns the checksum of the start state.
  `DFC_ASSERT(a_init_sum, init_xfer ##1 !out_valid_o |=> checksum_o == combine(RESET_SUMS))

endmodule

bind dual_fletcher_checksum_unit dfc_checker u_dfc_checker (.*);

`default_nettype wire
